// ----- rtl/dtsp_pkg.sv -----
// Shared types, constants and tier tables for the decode target size policy block.
// Used by dtsp_front, dtsp_cell and decode_target_size_policy_core.
package dtsp_pkg;

    localparam int DIM_BITS = 16;
    localparam int N_THUMB  = 7;
    localparam int N_VIEW   = 9;

    typedef logic [DIM_BITS-1:0]   t_dim;
    typedef logic [2*DIM_BITS-1:0] t_prod;
    typedef logic [DIM_BITS+3:0]   t_ext;

    localparam logic FAM_THUMB = 1'b0;

    localparam t_dim THUMB_TIERS [N_THUMB] = '{
        t_dim'(128), t_dim'(192), t_dim'(256), t_dim'(384),
        t_dim'(512), t_dim'(768), t_dim'(1024)
    };
    localparam t_dim VIEW_TIERS [N_VIEW] = '{
        t_dim'(512),  t_dim'(768),  t_dim'(1024), t_dim'(1536), t_dim'(2048),
        t_dim'(3072), t_dim'(4096), t_dim'(6144), t_dim'(8192)
    };

    typedef enum logic [2:0] {
        PATH_EMPTY  = 3'd0,
        PATH_PASS   = 3'd1,
        PATH_NATIVE = 3'd2,
        PATH_PREV   = 3'd3,
        PATH_TIER   = 3'd4
    } t_dtsp_path;

    typedef struct packed {
        logic req_type;
        logic expensive;
        t_dim req_width;
        t_dim req_height;
        logic native_valid;
        t_dim native_width;
        t_dim native_height;
        logic prev_valid;
        t_dim prev_width;
        t_dim prev_height;
    } t_dtsp_in;

    typedef struct packed {
        logic       out_valid;
        t_dim       out_width;
        t_dim       out_height;
        t_dtsp_path out_path;
    } t_dtsp_out;

    typedef struct packed {
        t_dtsp_path path;
        t_dim       fix_w;
        t_dim       fix_h;
        t_dim       tier;
        logic       wide;
        logic       use_div;
    } t_dtsp_meta;

    typedef struct packed {
        t_dtsp_meta meta;
        t_dim       shrt;
        t_dim       lng;
    } t_dtsp_plan;

    typedef struct packed {
        t_dtsp_meta meta;
        t_dim       rem;
        t_dim       low;
        t_dim       dvsr;
        t_dim       quo;
    } t_dtsp_beat;

    function automatic t_dim pick_tier(logic fam, t_dim edge_len);
        t_dim res;
        if (fam == FAM_THUMB) begin
            res = THUMB_TIERS[N_THUMB-1];
            for (int i = N_THUMB - 1; i >= 0; i--) begin
                if (THUMB_TIERS[i] >= edge_len) begin
                    res = THUMB_TIERS[i];
                end
            end
        end else begin
            res = VIEW_TIERS[N_VIEW-1];
            for (int i = N_VIEW - 1; i >= 0; i--) begin
                if (VIEW_TIERS[i] >= edge_len) begin
                    res = VIEW_TIERS[i];
                end
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/decode_target_size_policy_core.sv -----
// Decode target size policy: top level with rule stage, multiply stage,
// divider cell chain and output register. Depends on dtsp_pkg, dtsp_front, dtsp_cell.
//
// Use: present a request beat on i_in_data with i_in_valid; it is taken at a
// rising edge where o_in_stall is low. Every request gives exactly one result
// beat on o_out_data, in request order, taken where o_out_valid is high and
// i_out_stall is low.
// Pipeline: one rule stage, one multiply stage, one cell per quotient bit of the
// aspect division, and the output register. Throughput: one request per cycle
// while the output is not stalled; the cell chain starts a new division every
// cycle unless the pipeline is held.
// Reset: a synchronous active-low reset empties every stage; no result beat
// is shown until a request has come through.
// Stall: while a shown result is stalled, the whole pipeline holds and
// o_in_stall is raised; an empty output register never holds the pipeline.
module decode_target_size_policy_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtsp_pkg::t_dtsp_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtsp_pkg::t_dtsp_out o_out_data
);
    import dtsp_pkg::*;

    logic       adv;
    logic       front_valid;
    t_dtsp_plan front_plan;

    logic       r_mul_valid;
    t_dtsp_beat r_mul_beat;
    t_dtsp_beat n_mul_beat;

    logic       cell_valid [DIM_BITS+1];
    t_dtsp_beat cell_beat  [DIM_BITS+1];

    logic       r_out_valid;
    t_dtsp_out  r_out_data;
    t_dtsp_out  n_out_data;

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    dtsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (front_valid),
        .o_plan  (front_plan)
    );

    always_comb begin
        t_prod prod;
        prod = t_prod'(front_plan.shrt) * t_prod'(front_plan.meta.tier)
             + t_prod'(front_plan.lng) - t_prod'(1);
        n_mul_beat.meta = front_plan.meta;
        n_mul_beat.rem  = prod[2*DIM_BITS-1:DIM_BITS];
        n_mul_beat.low  = prod[DIM_BITS-1:0];
        n_mul_beat.dvsr = front_plan.lng;
        n_mul_beat.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (adv) begin
            r_mul_valid <= front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul_beat <= n_mul_beat;
        end
    end

    assign cell_valid[0] = r_mul_valid;
    assign cell_beat[0]  = r_mul_beat;

    for (genvar g = 0; g < DIM_BITS; g++) begin : g_cell
        dtsp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (cell_valid[g]),
            .i_beat  (cell_beat[g]),
            .o_valid (cell_valid[g+1]),
            .o_beat  (cell_beat[g+1])
        );
    end

    always_comb begin
        t_dtsp_beat fin;
        t_dim       scaled;
        fin    = cell_beat[DIM_BITS];
        scaled = (fin.quo == '0) ? t_dim'(1) : fin.quo;
        n_out_data.out_path = fin.meta.path;
        if (fin.meta.use_div) begin
            n_out_data.out_width  = fin.meta.wide ? fin.meta.tier : scaled;
            n_out_data.out_height = fin.meta.wide ? scaled : fin.meta.tier;
        end else begin
            n_out_data.out_width  = fin.meta.fix_w;
            n_out_data.out_height = fin.meta.fix_h;
        end
        n_out_data.out_valid = (n_out_data.out_width != '0) && (n_out_data.out_height != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cell_valid[DIM_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.out_path == PATH_EMPTY))
        |-> ((o_out_data.out_width == '0) && (o_out_data.out_height == '0)))
        else $error("empty result with nonzero size");

    a_tier_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.out_path == PATH_TIER))
        |-> ((o_out_data.out_width == '0) == (o_out_data.out_height == '0)))
        else $error("tier result with one zero edge");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && r_mul_valid) |=> (r_mul_valid && $stable(r_mul_beat)))
        else $error("multiply stage moved while held");

endmodule

// ----- rtl/dtsp_front.sv -----
// Front stage: applies the ordered size rules and picks the capped tier.
// Depends on dtsp_pkg.
module dtsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  dtsp_pkg::t_dtsp_in   i_data,
    output logic              o_valid,
    output dtsp_pkg::t_dtsp_plan o_plan
);
    import dtsp_pkg::*;

    logic       r_valid;
    t_dtsp_plan r_plan;
    t_dtsp_plan n_plan;

    always_comb begin
        t_dim re;
        t_dim ne;
        t_dim pe;
        t_dim tier;
        t_dim aw;
        t_dim ah;
        t_ext re10;
        t_ext pe11;
        re   = (i_data.req_width >= i_data.req_height) ? i_data.req_width : i_data.req_height;
        ne   = (i_data.native_width >= i_data.native_height) ?
               i_data.native_width : i_data.native_height;
        pe   = (i_data.prev_width >= i_data.prev_height) ? i_data.prev_width : i_data.prev_height;
        re10 = (t_ext'(re) << 3) + (t_ext'(re) << 1);
        pe11 = (t_ext'(pe) << 3) + (t_ext'(pe) << 1) + t_ext'(pe);
        tier = pick_tier(i_data.req_type, re);
        if (i_data.native_valid && (ne < tier)) begin
            tier = ne;
        end
        aw = i_data.native_valid ? i_data.native_width  : i_data.req_width;
        ah = i_data.native_valid ? i_data.native_height : i_data.req_height;

        n_plan.meta.path    = PATH_TIER;
        n_plan.meta.fix_w   = '0;
        n_plan.meta.fix_h   = '0;
        n_plan.meta.tier    = tier;
        n_plan.meta.wide    = (aw >= ah);
        n_plan.meta.use_div = 1'b0;
        n_plan.shrt         = (aw >= ah) ? ah : aw;
        n_plan.lng          = (aw >= ah) ? aw : ah;

        if ((i_data.req_width == '0) || (i_data.req_height == '0)) begin
            n_plan.meta.path = PATH_EMPTY;
        end else if (!i_data.expensive) begin
            n_plan.meta.path  = PATH_PASS;
            n_plan.meta.fix_w = i_data.req_width;
            n_plan.meta.fix_h = i_data.req_height;
        end else if (i_data.native_valid && (re >= ne)) begin
            n_plan.meta.path  = PATH_NATIVE;
            n_plan.meta.fix_w = i_data.native_width;
            n_plan.meta.fix_h = i_data.native_height;
        end else if (i_data.prev_valid && (re10 <= pe11)
                     && (!i_data.native_valid || (pe <= ne))) begin
            n_plan.meta.path  = PATH_PREV;
            n_plan.meta.fix_w = i_data.prev_width;
            n_plan.meta.fix_h = i_data.prev_height;
        end else begin
            n_plan.meta.use_div = (tier != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plan <= n_plan;
        end
    end

    assign o_valid = r_valid;
    assign o_plan  = r_plan;

endmodule

// ----- rtl/dtsp_cell.sv -----
// Divider cell: one restoring quotient bit per cell, registered toward the next cell.
// Depends on dtsp_pkg.
module dtsp_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  dtsp_pkg::t_dtsp_beat i_beat,
    output logic              o_valid,
    output dtsp_pkg::t_dtsp_beat o_beat
);
    import dtsp_pkg::*;

    logic       r_valid;
    t_dtsp_beat r_beat;
    t_dtsp_beat n_beat;

    always_comb begin
        logic [DIM_BITS:0] trial;
        logic [DIM_BITS:0] diff;
        logic              ge;
        trial = {i_beat.rem, i_beat.low[DIM_BITS-1]};
        diff  = trial - {1'b0, i_beat.dvsr};
        ge    = (trial >= {1'b0, i_beat.dvsr});

        n_beat      = i_beat;
        n_beat.rem  = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
        n_beat.low  = {i_beat.low[DIM_BITS-2:0], 1'b0};
        n_beat.quo  = {i_beat.quo[DIM_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- dv/tb.sv -----
// Testbench for decode_target_size_policy_core: directed and random size requests.
// A local predictor computes each result; a monitor checks every result beat in order.
// Depends on dtsp_pkg and decode_target_size_policy_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtsp_pkg::*;

    localparam longint unsigned DIM_LIMIT = (64'd1 << DIM_BITS) - 1;
    localparam longint unsigned THUMB_STEPS [7] = '{128, 192, 256, 384, 512, 768, 1024};
    localparam longint unsigned VIEW_STEPS [9] = '{
        512, 768, 1024, 1536, 2048, 3072, 4096, 6144, 8192
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_dtsp_in  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_dtsp_out o_out_data;

    t_dtsp_out   pending_sizes [$];
    int unsigned fail_count = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    decode_target_size_policy_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    function automatic t_dtsp_out predict_size(t_dtsp_in r);
        longint unsigned rw, rh, nw, nh, pw, ph;
        longint unsigned req_e, nat_e, prev_e, tier, aw, ah, s;
        longint unsigned w, h;
        t_dtsp_path      p;
        t_dtsp_out       res;
        logic            found;
        rw = r.req_width;
        rh = r.req_height;
        nw = r.native_width;
        nh = r.native_height;
        pw = r.prev_width;
        ph = r.prev_height;
        req_e = (rw > rh) ? rw : rh;
        nat_e = (nw > nh) ? nw : nh;
        prev_e = (pw > ph) ? pw : ph;
        if (rw == 0 || rh == 0) begin
            w = 0;
            h = 0;
            p = PATH_EMPTY;
        end else if (!r.expensive) begin
            w = rw;
            h = rh;
            p = PATH_PASS;
        end else if (r.native_valid && req_e >= nat_e) begin
            w = nw;
            h = nh;
            p = PATH_NATIVE;
        end else if (r.prev_valid && req_e <= (prev_e * 11) / 10
                     && (!r.native_valid || prev_e <= nat_e)) begin
            w = pw;
            h = ph;
            p = PATH_PREV;
        end else begin
            p = PATH_TIER;
            found = 1'b0;
            if (r.req_type == FAM_THUMB) begin
                tier = THUMB_STEPS[6];
                for (int i = 0; i < 7; i++) begin
                    if (!found && THUMB_STEPS[i] >= req_e) begin
                        tier = THUMB_STEPS[i];
                        found = 1'b1;
                    end
                end
            end else begin
                tier = VIEW_STEPS[8];
                for (int i = 0; i < 9; i++) begin
                    if (!found && VIEW_STEPS[i] >= req_e) begin
                        tier = VIEW_STEPS[i];
                        found = 1'b1;
                    end
                end
            end
            if (tier > DIM_LIMIT) begin
                tier = DIM_LIMIT;
            end
            if (r.native_valid && nat_e < tier) begin
                tier = nat_e;
            end
            aw = r.native_valid ? nw : rw;
            ah = r.native_valid ? nh : rh;
            if (tier == 0) begin
                w = 0;
                h = 0;
            end else if (aw >= ah) begin
                s = (aw != 0) ? (ah * tier + aw - 1) / aw : 0;
                w = tier;
                h = (s < 1) ? 1 : s;
            end else begin
                s = (aw * tier + ah - 1) / ah;
                w = (s < 1) ? 1 : s;
                h = tier;
            end
        end
        res.out_width = t_dim'(w);
        res.out_height = t_dim'(h);
        res.out_valid = (res.out_width != 0) && (res.out_height != 0);
        res.out_path = p;
        return res;
    endfunction

    function automatic t_dtsp_in mk_req(logic fam, logic costly, longint unsigned rw,
                                        longint unsigned rh, logic nv, longint unsigned nw,
                                        longint unsigned nh, logic pv, longint unsigned pw,
                                        longint unsigned ph);
        t_dtsp_in r;
        r.req_type = fam;
        r.expensive = costly;
        r.req_width = t_dim'(rw);
        r.req_height = t_dim'(rh);
        r.native_valid = nv;
        r.native_width = t_dim'(nw);
        r.native_height = t_dim'(nh);
        r.prev_valid = pv;
        r.prev_width = t_dim'(pw);
        r.prev_height = t_dim'(ph);
        return r;
    endfunction

    function automatic t_dim pick_dim();
        longint unsigned t;
        case ($urandom_range(0, 9))
            0: return t_dim'($urandom_range(0, 65535));
            1: return ($urandom_range(0, 1) != 0) ? t_dim'(DIM_LIMIT) : t_dim'(1);
            2: begin
                if ($urandom_range(0, 1) != 0) begin
                    t = THUMB_STEPS[$urandom_range(0, 6)];
                end else begin
                    t = VIEW_STEPS[$urandom_range(0, 8)];
                end
                return t_dim'(t + $urandom_range(0, 2) - 1);
            end
            3: return t_dim'($urandom_range(1, 16));
            4: return t_dim'($urandom_range(1, 12000));
            default: return t_dim'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic t_dim scale_dim(t_dim d, int unsigned pct);
        longint unsigned v;
        v = (longint'(d) * pct) / 100;
        return (v > DIM_LIMIT) ? t_dim'(DIM_LIMIT) : t_dim'(v);
    endfunction

    function automatic t_dtsp_in random_request();
        logic [127:0] raw;
        t_dtsp_in     r;
        int unsigned  k;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_dtsp_in)-1:0];
        if ($urandom_range(0, 99) < 85) begin
            r.expensive = ($urandom_range(0, 9) != 0);
            r.req_width = ($urandom_range(0, 49) == 0) ? t_dim'(0) : pick_dim();
            r.req_height = ($urandom_range(0, 49) == 0) ? t_dim'(0) : pick_dim();
            r.native_valid = ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 9);
            if (k == 0) begin
                r.native_width = pick_dim();
                r.native_height = pick_dim();
            end else if (k == 1) begin
                r.native_width = ($urandom_range(0, 1) != 0) ? t_dim'(0) : pick_dim();
                r.native_height = (r.native_width != 0) ? t_dim'(0) : pick_dim();
            end else begin
                r.native_width = scale_dim(r.req_width, $urandom_range(60, 900));
                r.native_height = scale_dim(r.req_height, $urandom_range(60, 900));
            end
            r.prev_valid = ($urandom_range(0, 2) != 0);
            k = $urandom_range(80, 125);
            r.prev_width = scale_dim(r.req_width, k);
            r.prev_height = scale_dim(r.req_height, k);
        end
        return r;
    endfunction

    task automatic report_mismatch(string line);
        fail_count++;
        if (fail_count <= 50) begin
            $display("[%0t] MISMATCH %s", $realtime, line);
        end
    endtask

    task automatic check_size(t_dtsp_out got);
        t_dtsp_out want;
        if (pending_sizes.size() == 0) begin
            report_mismatch($sformatf("result beat with no request pending: %p", got));
            return;
        end
        want = pending_sizes.pop_front();
        if (got.out_valid !== want.out_valid)
            report_mismatch($sformatf("out_valid got %0b want %0b", got.out_valid,
                                      want.out_valid));
        if (got.out_width !== want.out_width)
            report_mismatch($sformatf("out_width got %0d want %0d", got.out_width,
                                      want.out_width));
        if (got.out_height !== want.out_height)
            report_mismatch($sformatf("out_height got %0d want %0d", got.out_height,
                                      want.out_height));
        if (got.out_path !== want.out_path)
            report_mismatch($sformatf("out_path got %0d want %0d", got.out_path,
                                      want.out_path));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_size(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 4);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (stall_mode)
                0, 1: i_out_stall <= 1'b0;
                2: i_out_stall <= ($urandom_range(0, 3) == 0);
                3: i_out_stall <= ($urandom_range(0, 1) != 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_req(t_dtsp_in r);
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        pending_sizes.push_back(predict_size(r));
    endtask

    task automatic hold_off(int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_request();
        send_req(mk_req(0, 1, 0, 5, 1, 100, 100, 1, 10, 10));
        send_req(mk_req(1, 1, 7, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(1, 0, 0, 0, 1, 65535, 65535, 1, 65535, 65535));
    endtask

    task automatic test_passthrough();
        send_req(mk_req(1, 0, 65535, 65535, 1, 100, 100, 1, 65535, 65535));
        send_req(mk_req(0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_native_size();
        send_req(mk_req(0, 1, 4000, 3000, 1, 1920, 1080, 1, 4000, 3000));
        send_req(mk_req(1, 1, 1920, 10, 1, 1920, 1080, 0, 0, 0));
        send_req(mk_req(1, 1, 600, 600, 1, 0, 500, 0, 0, 0));
        send_req(mk_req(0, 1, 1, 1, 1, 0, 0, 1, 50, 50));
    endtask

    task automatic test_keep_previous();
        send_req(mk_req(1, 1, 1100, 300, 1, 4000, 3000, 1, 1000, 800));
        send_req(mk_req(1, 1, 1101, 300, 1, 4000, 3000, 1, 1000, 800));
        send_req(mk_req(0, 1, 500, 200, 1, 900, 900, 1, 1000, 800));
        send_req(mk_req(0, 1, 330, 100, 1, 2000, 2000, 1, 0, 300));
        send_req(mk_req(1, 1, 60000, 10, 0, 0, 0, 1, 65535, 65535));
    endtask

    task automatic test_tier_choice();
        send_req(mk_req(0, 1, 100, 80, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(0, 1, 1024, 1024, 1, 3000, 2000, 0, 0, 0));
        send_req(mk_req(0, 1, 1025, 900, 1, 3000, 2000, 0, 0, 0));
        send_req(mk_req(1, 1, 8192, 4000, 1, 20000, 15000, 0, 0, 0));
        send_req(mk_req(1, 1, 9000, 4000, 0, 0, 0, 1, 10, 10));
        send_req(mk_req(0, 1, 700, 300, 1, 720, 480, 0, 0, 0));
        send_req(mk_req(0, 1, 200, 200, 1, 300, 5000, 0, 0, 0));
        send_req(mk_req(0, 1, 200, 200, 1, 0, 5000, 0, 0, 0));
        send_req(mk_req(0, 1, 65535, 1, 0, 0, 0, 0, 0, 0));
        send_req(mk_req(1, 1, 1, 65534, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned burst;
        burst = $urandom_range(1, 16);
        for (int unsigned i = 0; i < n_items; i++) begin
            send_req(random_request());
            if (i == n_items / 2) begin
                wait_drained();
            end else begin
                burst--;
                if (burst == 0) begin
                    hold_off($urandom_range(1, 8));
                    burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_request();
        test_passthrough();
        test_native_size();
        test_keep_previous();
        test_tier_choice();
        wait_drained();
        test_random_traffic(800);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** decode_target_size_policy_core: PASSED **");
        end else begin
            $display("** decode_target_size_policy_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** decode_target_size_policy_core: FAILED **");
        $finish;
    end

endmodule
